### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ABST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/abst_pkg.sv
// Shared constants, types and command/status structs of the blower tuner.
// No dependencies.
package abst_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int DAC_BITS_DEF    = 12;
    localparam int DAC_BITS_MAX    = 16;
    localparam int WIDE_W          = DAC_BITS_MAX + 1;

    localparam int FUNC_W   = 2;
    localparam int PRESS_W  = 8;
    localparam int PRESET_W = 12;
    localparam int CODE_W   = 12;
    localparam int AVG_W    = 8;
    localparam int STEP_W   = 6;

    localparam logic [AVG_W-1:0] SET_PRESSURE_RST = AVG_W'(5);

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRESET = 2'd2;

    localparam logic [AVG_W-1:0]  BAND_MID   = AVG_W'(2);
    localparam logic [AVG_W-1:0]  BAND_HIGH  = AVG_W'(4);
    localparam logic [STEP_W-1:0] STEP_SMALL = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_MID   = STEP_W'(20);
    localparam logic [STEP_W-1:0] STEP_LARGE = STEP_W'(40);

    // Average is at most 255, so the quotient needs AVG_W restoring steps.
    localparam int DIV_STEPS = AVG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic sample;         // add pressure to the window
        logic capture_close;  // latch window into divider, clear accumulators
        logic capture_preset; // latch preset code
        logic div_step;       // one restoring division step
        logic commit;         // update DAC code and load result register
    } cmd_t;

    typedef struct packed {
        logic window_empty;   // count or sum is zero
    } stat_t;

    function automatic logic [STEP_W-1:0] band_step(input logic [AVG_W-1:0] d);
        logic [STEP_W-1:0] s;
        begin
            if (d == '0)
                s = '0;
            else if (d < BAND_MID)
                s = STEP_SMALL;
            else if (d < BAND_HIGH)
                s = STEP_MID;
            else
                s = STEP_LARGE;
            return s;
        end
    endfunction

endpackage

### hdl/abst_if.sv
// Valid/ready channel interfaces: input item, result item, config write.
// Depends on abst_pkg.
interface abst_in_if import abst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PRESS_W-1:0]  pressure;
    logic [PRESET_W-1:0] dac_preset;

    modport source (output valid, func, pressure, dac_preset, input ready);
    modport sink   (input valid, func, pressure, dac_preset, output ready);
endinterface

interface abst_out_if import abst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic [AVG_W-1:0]  average;
    logic              on_target;
    logic              clipped;

    modport source (output valid, dac_code, average, on_target, clipped, input ready);
    modport sink   (input valid, dac_code, average, on_target, clipped, output ready);
endinterface

interface abst_cfg_if import abst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/abst_ctrl.sv
// Controller FSM of the blower tuner: handshakes, division sequencing, commit.
// Depends on abst_pkg.
module abst_ctrl
    import abst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  stat_t             stat,
    output cmd_t              cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 in_acc;
    logic                 out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_func == FUNC_ADD)
                    begin
                        cmd.sample = 1'b1;
                    end
                    else if (in_func == FUNC_CLOSE)
                    begin
                        cmd.capture_close = 1'b1;
                        step_next         = DIV_CNT_W'(DIV_STEPS - 1);
                        // empty window has a fixed average, no division
                        state_next        = stat.window_empty ? S_LOAD : S_DIV;
                    end
                    else if (in_func == FUNC_PRESET)
                    begin
                        cmd.capture_preset = 1'b1;
                        state_next         = S_LOAD;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - DIV_CNT_W'(1);
                if (step_reg == '0)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/abst_dp.sv
// Datapath of the blower tuner: window accumulators, restoring divider,
// banded step with saturation, DAC code and result registers. Uses abst_pkg.
module abst_dp
    import abst_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int DAC_BITS    = DAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [PRESS_W-1:0]  pressure,
    input  logic [PRESET_W-1:0] dac_preset,
    input  logic                cfg_we,
    input  logic [AVG_W-1:0]    cfg_data,
    output logic [CODE_W-1:0]   dac_code,
    output logic [AVG_W-1:0]    average,
    output logic                on_target,
    output logic                clipped
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = CNT_W + PRESS_W;
    localparam int CW    = DAC_BITS + 1;
    localparam logic [CNT_W-1:0]    CNT_MAX    = CNT_W'(MAX_SAMPLES);
    localparam logic [DAC_BITS-1:0] FULL_SCALE = '1;

    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DAC_BITS-1:0] code_reg;
    logic [AVG_W-1:0]    sp_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    dvs_reg;
    logic [AVG_W-1:0]    quo_reg;
    logic [PRESET_W-1:0] preset_reg;
    logic                is_preset_reg;
    logic [CODE_W-1:0]   dac_code_reg;
    logic [AVG_W-1:0]    avg_out_reg;
    logic                on_target_reg;
    logic                clipped_reg;

    logic                above;
    logic [AVG_W-1:0]    diff;
    logic [STEP_W-1:0]   step;
    logic [CW-1:0]       step_w;
    logic [CW-1:0]       up_sum;
    logic [WIDE_W-1:0]   preset_w;
    logic                preset_clip;
    logic [DAC_BITS-1:0] code_new;
    logic                clip_new;
    logic [WIDE_W-1:0]   code_new_w;
    logic                rem_ge;

    assign stat.window_empty = (cnt_reg == '0) || (sum_reg == '0);

    assign rem_ge = (rem_reg >= dvs_reg);

    // Tune step from window average
    assign above  = quo_reg > sp_reg;
    assign diff   = above ? (quo_reg - sp_reg) : (sp_reg - quo_reg);
    assign step   = band_step(diff);
    assign step_w = CW'(step);
    assign up_sum = {1'b0, code_reg} + step_w;

    assign preset_w    = WIDE_W'(preset_reg);
    assign preset_clip = preset_w > WIDE_W'(FULL_SCALE);

    always_comb
    begin
        code_new = code_reg;
        clip_new = 1'b0;
        if (is_preset_reg)
        begin
            code_new = preset_clip ? FULL_SCALE : preset_w[DAC_BITS-1:0];
            clip_new = preset_clip;
        end
        else if (above)
        begin
            if (step_w > {1'b0, code_reg})
            begin
                code_new = '0;
                clip_new = 1'b1;
            end
            else
            begin
                code_new = code_reg - step_w[DAC_BITS-1:0];
            end
        end
        else
        begin
            if (up_sum > {1'b0, FULL_SCALE})
            begin
                code_new = FULL_SCALE;
                clip_new = 1'b1;
            end
            else
            begin
                code_new = up_sum[DAC_BITS-1:0];
            end
        end
    end

    assign code_new_w = WIDE_W'(code_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            code_reg <= '0;
            sp_reg   <= SET_PRESSURE_RST;
        end
        else
        begin
            if (cfg_we)
                sp_reg <= cfg_data;
            if (cmd.sample && (cnt_reg < CNT_MAX))
            begin
                sum_reg <= sum_reg + SUM_W'(pressure);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.capture_close)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.commit)
                code_reg <= code_new;
        end
    end

    // Divider, preset latch and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture_close)
        begin
            rem_reg       <= sum_reg;
            dvs_reg       <= {1'b0, cnt_reg, {(AVG_W - 1){1'b0}}};
            quo_reg       <= stat.window_empty ? AVG_W'(1) : '0;
            is_preset_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - dvs_reg;
            quo_reg <= {quo_reg[AVG_W-2:0], rem_ge};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.capture_preset)
        begin
            preset_reg    <= dac_preset;
            is_preset_reg <= 1'b1;
        end
        if (cmd.commit)
        begin
            dac_code_reg  <= code_new_w[CODE_W-1:0];
            avg_out_reg   <= is_preset_reg ? '0 : quo_reg;
            on_target_reg <= !is_preset_reg && (quo_reg == sp_reg);
            clipped_reg   <= clip_new;
        end
    end

    assign dac_code  = dac_code_reg;
    assign average   = avg_out_reg;
    assign on_target = on_target_reg;
    assign clipped   = clipped_reg;

endmodule

### hdl/averaged_band_step_blower_tuner_top.sv
// Top level of the breath-by-breath blower tuner: controller plus datapath.
// Depends on abst_pkg, abst_if, abst_ctrl, abst_dp.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------
//  item    | in  | func, pressure, dac_preset
//  result  | out | dac_code, average, on_target, clipped
//  cfg     | in  | data (set_pressure), always ready
//
// A sample beat produces no result. A close beat runs: accept, 8
// restoring divider steps (one quotient bit each), commit; an empty window
// skips the divider, as does a preset beat.
// Commit waits while the result register holds a beat not yet taken.
// rst_n clears the accumulators, DAC code and set pressure (to 5).
module averaged_band_step_blower_tuner_top
    import abst_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int DAC_BITS    = DAC_BITS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    abst_in_if.sink   item,
    abst_out_if.source result,
    abst_cfg_if.sink  cfg
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;
    logic  out_valid;

    assign item.ready   = in_ready;
    assign result.valid = out_valid;
    assign cfg.ready    = 1'b1;

    abst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_func   (item.func),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    abst_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .DAC_BITS    (DAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .pressure   (item.pressure),
        .dac_preset (item.dac_preset),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .dac_code   (result.dac_code),
        .average    (result.average),
        .on_target  (result.on_target),
        .clipped    (result.clipped)
    );

endmodule

### hdl/abst_checker.sv
// Port-level checker for the blower tuner, bound to the top level.
// Depends on abst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abst_checker
    import abst_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [FUNC_W-1:0]   in_func,
    input logic                out_valid,
    input logic                out_ready,
    input logic [CODE_W-1:0]   out_dac_code,
    input logic [AVG_W-1:0]    out_average,
    input logic                out_on_target,
    input logic                out_clipped
);

    logic in_acc;
    logic makes_result;

    assign in_acc       = in_valid && in_ready;
    assign makes_result = (in_func == FUNC_CLOSE) || (in_func == FUNC_PRESET);

    `ABST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_dac_code) && $stable(out_average) &&
        $stable(out_on_target) && $stable(out_clipped), "result beat dropped or changed")

    `ABST_ASSERT_NEXT(a_sample_silent, in_acc && (in_func == FUNC_ADD) && !out_valid,
        !out_valid, "sample beat produced a result")

    `ABST_ASSERT_NEXT(a_busy_after_cmd, in_acc && makes_result,
        !in_ready, "input still ready while a close or preset is in work")

    `ABST_ASSERT_NOW(a_no_result_idle_rise, $rose(out_valid),
        $past(!in_ready), "result appeared without a close or preset in work")

endmodule

bind averaged_band_step_blower_tuner_top abst_checker u_abst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .in_func       (item.func),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_dac_code  (result.dac_code),
    .out_average   (result.average),
    .out_on_target (result.on_target),
    .out_clipped   (result.clipped)
);
